// ----- rtl/bmtc_pkg.sv -----
package bmtc_pkg;

  localparam int PHASE_COUNT = 4;
  localparam int PHASE_W = $clog2(PHASE_COUNT);
  localparam int COIL_W = 12;
  localparam int TIME_W = 32;
  localparam int CODE_W = 32;
  localparam int FLASH_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [FLASH_W-1:0] FLASH_INTERVAL_RST = 16'd125;
  localparam logic [CODE_W-1:0] REMOTE_CLOSE_RST = 32'h02FD807F;
  localparam logic [CODE_W-1:0] REMOTE_OPEN_RST = 32'h02FD40BF;

  localparam logic [COIL_W-1:0] COIL_TABLE [PHASE_COUNT] = '{
    12'd3276, 12'd1638, 12'd819, 12'd2457
  };

  typedef enum logic [2:0] {
    MODE_OPEN       = 3'd0,
    MODE_CLOSE      = 3'd1,
    MODE_AUTO_OPEN  = 3'd2,
    MODE_AUTO_CLOSE = 3'd3,
    MODE_STOP       = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLASH_INTERVAL = 2'd0,
    REG_REMOTE_CLOSE   = 2'd1,
    REG_REMOTE_OPEN    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [FLASH_W-1:0] flash_interval_ms;
    logic [CODE_W-1:0]  remote_close_code;
    logic [CODE_W-1:0]  remote_open_code;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              close_pressed;
    logic              open_pressed;
    logic              calibrate_pressed;
    logic [CODE_W-1:0] remote_code;
  } item_t;

  typedef struct packed {
    logic [COIL_W-1:0] coil_pattern;
    logic              led_lit;
    logic [2:0]        drive_mode;
    logic              in_calibration;
    logic [TIME_W-1:0] travel_ms;
  } result_t;

endpackage

// ----- rtl/bmtc_if.sv -----
interface bmtc_in_if;
  logic                         valid;
  logic                         ready;
  logic [bmtc_pkg::TIME_W-1:0]  now_ms;
  logic                         close_pressed;
  logic                         open_pressed;
  logic                         calibrate_pressed;
  logic [bmtc_pkg::CODE_W-1:0]  remote_code;

  modport source (output valid, now_ms, close_pressed, open_pressed, calibrate_pressed,
                  remote_code, input ready);
  modport sink (input valid, now_ms, close_pressed, open_pressed, calibrate_pressed,
                remote_code, output ready);
endinterface

interface bmtc_out_if;
  logic                         valid;
  logic                         ready;
  logic [bmtc_pkg::COIL_W-1:0]  coil_pattern;
  logic                         led_lit;
  logic [2:0]                   drive_mode;
  logic                         in_calibration;
  logic [bmtc_pkg::TIME_W-1:0]  travel_ms;

  modport source (output valid, coil_pattern, led_lit, drive_mode, in_calibration,
                  travel_ms, input ready);
  modport sink (input valid, coil_pattern, led_lit, drive_mode, in_calibration,
                travel_ms, output ready);
endinterface

// ----- rtl/bmtc_cfg_regs.sv -----
module bmtc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bmtc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [bmtc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output bmtc_pkg::cfg_t                    cfg
);

  bmtc_pkg::cfg_t cfg_r;
  bmtc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        bmtc_pkg::REG_FLASH_INTERVAL: begin
          cfg_nxt.flash_interval_ms = cfg_wdata[bmtc_pkg::FLASH_W-1:0];
        end
        bmtc_pkg::REG_REMOTE_CLOSE: begin
          cfg_nxt.remote_close_code = cfg_wdata[bmtc_pkg::CODE_W-1:0];
        end
        bmtc_pkg::REG_REMOTE_OPEN: begin
          cfg_nxt.remote_open_code = cfg_wdata[bmtc_pkg::CODE_W-1:0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flash_interval_ms <= bmtc_pkg::FLASH_INTERVAL_RST;
      cfg_r.remote_close_code <= bmtc_pkg::REMOTE_CLOSE_RST;
      cfg_r.remote_open_code  <= bmtc_pkg::REMOTE_OPEN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/bmtc_tick_logic.sv -----
module bmtc_tick_logic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  bmtc_pkg::item_t    item,
  input  bmtc_pkg::cfg_t     cfg,
  output bmtc_pkg::result_t  res
);

  logic                                 calib_r, calib_nxt;
  logic                                 led_r, led_nxt;
  logic [bmtc_pkg::TIME_W-1:0]          flash_mark_r, flash_mark_nxt;
  logic                                 prev_cal_r, prev_close_r, prev_open_r;
  logic                                 measuring_r, measuring_nxt;
  logic [bmtc_pkg::TIME_W-1:0]          measure_start_r, measure_start_nxt;
  logic [bmtc_pkg::TIME_W-1:0]          travel_r, travel_nxt;
  bmtc_pkg::mode_t                      mode_r, mode_nxt;
  logic                                 auto_run_r, auto_run_nxt;
  logic [bmtc_pkg::TIME_W-1:0]          auto_start_r, auto_start_nxt;
  logic [bmtc_pkg::PHASE_W-1:0]         phase_r, phase_nxt;
  logic [bmtc_pkg::COIL_W-1:0]          coil_r, coil_nxt;

  logic                                 step_en;
  logic                                 step_fwd;
  bmtc_pkg::mode_t                      mode_a;

  always_comb begin
    calib_nxt         = calib_r;
    led_nxt           = led_r;
    flash_mark_nxt    = flash_mark_r;
    measuring_nxt     = measuring_r;
    measure_start_nxt = measure_start_r;
    travel_nxt        = travel_r;
    mode_a            = mode_r;
    auto_run_nxt      = auto_run_r;
    auto_start_nxt    = auto_start_r;
    phase_nxt         = phase_r;
    coil_nxt          = coil_r;
    step_en           = 1'b0;
    step_fwd          = 1'b0;

    if (item.calibrate_pressed && !prev_cal_r) begin
      calib_nxt = !calib_r;
    end

    if (calib_nxt) begin
      if (flash_mark_r == '0) begin
        flash_mark_nxt = item.now_ms;
      end else if ((item.now_ms - flash_mark_r) >
                   {{(bmtc_pkg::TIME_W-bmtc_pkg::FLASH_W){1'b0}}, cfg.flash_interval_ms}) begin
        led_nxt        = !led_r;
        flash_mark_nxt = '0;
      end
    end else begin
      led_nxt = 1'b0;
    end

    if (item.close_pressed != prev_close_r) begin
      if (calib_nxt) begin
        mode_a = item.close_pressed ? bmtc_pkg::MODE_CLOSE : bmtc_pkg::MODE_STOP;
      end else if (item.close_pressed) begin
        mode_a = bmtc_pkg::MODE_AUTO_CLOSE;
      end
    end

    if (calib_nxt) begin
      if (item.open_pressed) begin
        if (!measuring_r) begin
          measuring_nxt     = 1'b1;
          measure_start_nxt = item.now_ms;
        end
        mode_a = bmtc_pkg::MODE_OPEN;
      end else if (measuring_r) begin
        travel_nxt    = item.now_ms - measure_start_r;
        mode_a        = bmtc_pkg::MODE_STOP;
        measuring_nxt = 1'b0;
        calib_nxt     = 1'b0;
      end
    end else if (item.open_pressed && !prev_open_r) begin
      mode_a = bmtc_pkg::MODE_AUTO_OPEN;
    end

    if (!calib_nxt && (item.remote_code != '0)) begin
      if ((item.remote_code == cfg.remote_close_code) &&
          (mode_a != bmtc_pkg::MODE_AUTO_CLOSE)) begin
        mode_a = bmtc_pkg::MODE_AUTO_CLOSE;
      end else if ((item.remote_code == cfg.remote_open_code) &&
                   (mode_a != bmtc_pkg::MODE_AUTO_OPEN)) begin
        mode_a = bmtc_pkg::MODE_AUTO_OPEN;
      end
    end

    mode_nxt = mode_a;

    case (mode_a)
      bmtc_pkg::MODE_AUTO_OPEN, bmtc_pkg::MODE_AUTO_CLOSE: begin
        step_fwd = (mode_a == bmtc_pkg::MODE_AUTO_OPEN);
        if (!auto_run_r) begin
          auto_run_nxt   = 1'b1;
          auto_start_nxt = item.now_ms;
          step_en        = 1'b1;
        end else if ((item.now_ms - auto_start_r) >= travel_nxt) begin
          auto_run_nxt   = 1'b0;
          auto_start_nxt = '0;
          mode_nxt       = bmtc_pkg::MODE_STOP;
        end else begin
          step_en = 1'b1;
        end
      end
      bmtc_pkg::MODE_OPEN: begin
        step_en  = 1'b1;
        step_fwd = 1'b1;
      end
      bmtc_pkg::MODE_CLOSE: begin
        step_en  = 1'b1;
        step_fwd = 1'b0;
      end
      default: begin
        coil_nxt = '0;
      end
    endcase

    if (step_en) begin
      coil_nxt  = bmtc_pkg::COIL_TABLE[phase_r];
      phase_nxt = step_fwd ? phase_r + 1'b1 : phase_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_r         <= 1'b0;
      led_r           <= 1'b0;
      flash_mark_r    <= '0;
      prev_cal_r      <= 1'b0;
      prev_close_r    <= 1'b0;
      prev_open_r     <= 1'b0;
      measuring_r     <= 1'b0;
      measure_start_r <= '0;
      travel_r        <= '0;
      mode_r          <= bmtc_pkg::MODE_STOP;
      auto_run_r      <= 1'b0;
      auto_start_r    <= '0;
      phase_r         <= '0;
      coil_r          <= '0;
    end else if (advance) begin
      calib_r         <= calib_nxt;
      led_r           <= led_nxt;
      flash_mark_r    <= flash_mark_nxt;
      prev_cal_r      <= item.calibrate_pressed;
      prev_close_r    <= item.close_pressed;
      prev_open_r     <= item.open_pressed;
      measuring_r     <= measuring_nxt;
      measure_start_r <= measure_start_nxt;
      travel_r        <= travel_nxt;
      mode_r          <= mode_nxt;
      auto_run_r      <= auto_run_nxt;
      auto_start_r    <= auto_start_nxt;
      phase_r         <= phase_nxt;
      coil_r          <= coil_nxt;
    end
  end

  always_comb begin
    res.coil_pattern   = coil_nxt;
    res.led_lit        = led_nxt;
    res.drive_mode     = mode_nxt;
    res.in_calibration = calib_nxt;
    res.travel_ms      = travel_nxt;
  end

endmodule

// ----- rtl/blind_motor_travel_controller.sv -----
// Flow: a beat accepted at a clock edge is held in the input register; its result is
// captured in the result register once the output slot is free, and then offered.
// Throughput: one beat per cycle unless out_ch stalls; input and result registers
// form a two-stage pipeline, and the tick logic between them updates control state.
// Reset: synchronous and active low; it empties both stages, restores the register
// defaults and returns the control state to stop with the calibration mode off.
module blind_motor_travel_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  bmtc_in_if.sink                           in_ch,
  bmtc_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [bmtc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [bmtc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  bmtc_pkg::cfg_t     cfg;
  bmtc_pkg::item_t    item_r;
  bmtc_pkg::result_t  res;
  bmtc_pkg::result_t  res_r;
  logic               in_v_r, in_v_nxt;
  logic               out_v_r, out_v_nxt;
  logic               advance;
  logic               in_rdy;

  bmtc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bmtc_tick_logic u_tick (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item_r),
    .cfg     (cfg),
    .res     (res)
  );

  assign advance = in_v_r && (!out_v_r || out_ch.ready);
  assign in_rdy  = !in_v_r || advance;

  always_comb begin
    in_v_nxt = in_rdy ? in_ch.valid : in_v_r;
    if (advance) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_rdy) begin
      item_r.now_ms            <= in_ch.now_ms;
      item_r.close_pressed     <= in_ch.close_pressed;
      item_r.open_pressed      <= in_ch.open_pressed;
      item_r.calibrate_pressed <= in_ch.calibrate_pressed;
      item_r.remote_code       <= in_ch.remote_code;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign in_ch.ready           = in_rdy;
  assign out_ch.valid          = out_v_r;
  assign out_ch.coil_pattern   = res_r.coil_pattern;
  assign out_ch.led_lit        = res_r.led_lit;
  assign out_ch.drive_mode     = res_r.drive_mode;
  assign out_ch.in_calibration = res_r.in_calibration;
  assign out_ch.travel_ms      = res_r.travel_ms;

endmodule
